>>> design/tls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_pkg
// types, codes and constants shared by the light sequencer files
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int CFG_BITS      = 16;
  localparam int POT_BITS      = 10;
  localparam int LEVEL_BITS    = 8;

  localparam int GREEN_STEP    = 143;
  localparam int BLINK_STEP    = 500;
  localparam int GREEN_TOGGLES = 7;
  localparam int LEVEL_RESET   = 255;

  localparam logic [CFG_BITS-1:0] RED_TIME_RESET    = 16'd2000;
  localparam logic [CFG_BITS-1:0] YELLOW_TIME_RESET = 16'd500;
  localparam logic [CFG_BITS-1:0] GREEN_TIME_RESET  = 16'd2000;

  // lamp flag bits: red, yellow, green from lsb
  localparam logic [2:0] LAMP_OFF    = 3'b000;
  localparam logic [2:0] LAMP_RED    = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_GREEN  = 3'b100;
  localparam logic [2:0] LAMP_ALL    = 3'b111;

  typedef enum logic [2:0] {
    REQ_TICK = 3'd0,
    REQ_BTN1 = 3'd1,
    REQ_BTN2 = 3'd2,
    REQ_BTN3 = 3'd3,
    REQ_MODE = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    MODE_CYCLE = 2'd0,
    MODE_RED   = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_OFF   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_RED     = 3'd0,
    PH_YELLOW  = 3'd1,
    PH_GREEN   = 3'd2,
    PH_BLINK   = 3'd3,
    PH_YELLOW2 = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CFG_RED_TIME    = 2'd0,
    CFG_YELLOW_TIME = 2'd1,
    CFG_GREEN_TIME  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] red_time;
    logic [CFG_BITS-1:0] yellow_time;
    logic [CFG_BITS-1:0] green_time;
  } cfg_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] new_mode;
  } item_t;

  // sequencer state apart from the phase timer
  typedef struct packed {
    mode_t                 mode;
    phase_t                phase;
    logic [2:0]            toggle_count;
    logic                  blink_lit;
    logic [2:0]            lamps;
    logic [LEVEL_BITS-1:0] level;
  } ctrl_t;

endpackage

>>> design/tls_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_level
// lamp drive level from a potentiometer sample, pot * 255 / 1023 truncated
// ----------------------------------------------------------------------------
module tls_level (
  input  logic [tls_pkg::POT_BITS-1:0]   pot,
  output logic [tls_pkg::LEVEL_BITS-1:0] level
);

  // x = pot * 255, then x / 1023 = (x + (x >> 10) + 1) >> 10 for this range
  logic [17:0] prod;
  logic [17:0] sum;

  always_comb begin
    prod  = {pot, 8'd0} - {8'd0, pot};
    sum   = prod + {10'd0, prod[17:10]} + 18'd1;
    level = sum[17:10];
  end

endmodule

>>> design/tls_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_seq
// next sequencer state for one item
// ----------------------------------------------------------------------------
module tls_seq #(
  parameter int TIME_BITS = tls_pkg::TIME_BITS_DEF
) (
  input  tls_pkg::ctrl_t                 cur,
  input  logic [TIME_BITS-1:0]           elapsed_cur,
  input  tls_pkg::item_t                 item,
  input  tls_pkg::cfg_t                  cfg,
  input  logic [tls_pkg::LEVEL_BITS-1:0] tick_level,
  output tls_pkg::ctrl_t                 nxt,
  output logic [TIME_BITS-1:0]           elapsed_nxt
);

  localparam int CW = (TIME_BITS > tls_pkg::CFG_BITS) ? TIME_BITS : tls_pkg::CFG_BITS;

  logic [TIME_BITS-1:0] e_inc;
  logic [TIME_BITS:0]   e_plus;
  logic [CW-1:0]        phase_len;
  logic                 reached;
  logic                 blink_wrap;
  logic [2:0]           toggle_inc;
  tls_pkg::mode_t       btn_mode;

  function automatic tls_pkg::ctrl_t enter_mode(tls_pkg::ctrl_t c, tls_pkg::mode_t m);
    tls_pkg::ctrl_t r;
    r              = c;
    r.mode         = m;
    r.phase        = tls_pkg::PH_RED;
    r.toggle_count = 3'd0;
    r.blink_lit    = 1'b0;
    r.lamps        = (m == tls_pkg::MODE_CYCLE) ? tls_pkg::LAMP_RED : tls_pkg::LAMP_OFF;
    return r;
  endfunction

  always_comb begin
    // saturating tick count
    e_inc  = (elapsed_cur == '1) ? elapsed_cur : elapsed_cur + 1'b1;
    e_plus = {1'b0, elapsed_cur} + 1'b1;

    case (cur.phase)
      tls_pkg::PH_RED:     phase_len = CW'(cfg.red_time);
      tls_pkg::PH_YELLOW:  phase_len = CW'(cfg.yellow_time);
      tls_pkg::PH_GREEN:   phase_len = CW'(cfg.green_time);
      tls_pkg::PH_BLINK:   phase_len = CW'(tls_pkg::GREEN_STEP);
      tls_pkg::PH_YELLOW2: phase_len = CW'(cfg.yellow_time);
      default:             phase_len = '0;
    endcase
    reached    = CW'(e_inc) >= phase_len;
    blink_wrap = (CW + 1)'(e_plus) >= (CW + 1)'(tls_pkg::BLINK_STEP);
    toggle_inc = cur.toggle_count + 3'd1;
    btn_mode   = (cur.mode != tls_pkg::mode_t'(item.req_type[1:0])) ?
                 tls_pkg::mode_t'(item.req_type[1:0]) : tls_pkg::MODE_CYCLE;

    nxt         = cur;
    elapsed_nxt = elapsed_cur;

    case (item.req_type) inside
      tls_pkg::REQ_TICK: begin
        nxt.level = tick_level;
        case (cur.mode)
          tls_pkg::MODE_CYCLE: begin
            elapsed_nxt = reached ? '0 : e_inc;
            case (cur.phase)
              tls_pkg::PH_RED: begin
                if (reached) begin
                  nxt.phase = tls_pkg::PH_YELLOW;
                  nxt.lamps = tls_pkg::LAMP_YELLOW;
                end
              end
              tls_pkg::PH_YELLOW: begin
                if (reached) begin
                  nxt.phase = tls_pkg::PH_GREEN;
                  nxt.lamps = tls_pkg::LAMP_GREEN;
                end
              end
              tls_pkg::PH_GREEN: begin
                if (reached) begin
                  nxt.phase        = tls_pkg::PH_BLINK;
                  nxt.lamps        = tls_pkg::LAMP_OFF;
                  nxt.toggle_count = 3'd0;
                end
              end
              tls_pkg::PH_BLINK: begin
                if (reached) begin
                  // a toggle taken with an odd toggle_count relights green, an even one switches it off
                  nxt.lamps        = cur.toggle_count[0] ? tls_pkg::LAMP_GREEN
                                                         : tls_pkg::LAMP_OFF;
                  nxt.toggle_count = toggle_inc;
                  if (toggle_inc >= 3'(tls_pkg::GREEN_TOGGLES)) begin
                    nxt.toggle_count = 3'd0;
                    nxt.phase        = tls_pkg::PH_YELLOW2;
                    nxt.lamps        = tls_pkg::LAMP_YELLOW;
                  end
                end
              end
              tls_pkg::PH_YELLOW2: begin
                if (reached) begin
                  nxt.phase = tls_pkg::PH_RED;
                  nxt.lamps = tls_pkg::LAMP_RED;
                end
              end
              default: begin
                // corrupt phase restarts the cycle
                nxt.phase        = tls_pkg::PH_RED;
                nxt.lamps        = tls_pkg::LAMP_RED;
                nxt.toggle_count = 3'd0;
                elapsed_nxt      = '0;
              end
            endcase
          end
          tls_pkg::MODE_RED: nxt.lamps = tls_pkg::LAMP_RED;
          tls_pkg::MODE_BLINK: begin
            if (elapsed_cur == '0) begin
              nxt.blink_lit = ~cur.blink_lit;
              nxt.lamps     = cur.blink_lit ? tls_pkg::LAMP_OFF : tls_pkg::LAMP_ALL;
            end
            elapsed_nxt = blink_wrap ? '0 : e_inc;
          end
          default: nxt.lamps = tls_pkg::LAMP_OFF;
        endcase
      end
      tls_pkg::REQ_BTN1, tls_pkg::REQ_BTN2, tls_pkg::REQ_BTN3: begin
        nxt         = enter_mode(cur, btn_mode);
        elapsed_nxt = '0;
      end
      tls_pkg::REQ_MODE: begin
        if (tls_pkg::mode_t'(item.new_mode) != cur.mode) begin
          nxt         = enter_mode(cur, tls_pkg::mode_t'(item.new_mode));
          elapsed_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/traffic_light_sequencer_core.sv
`timescale 1ns / 1ps
// an accepted item is held in the input register and then passes into the result register
// throughput: one item per cycle while the result side does not stall, set by the state update loop
// back-pressure on the result side stalls the input once both registers hold an item
// reset (synchronous, active low): cycle mode, red phase, red lamp lit, level 255,
// phase times back to 2000 / 500 / 2000 ticks
// ----------------------------------------------------------------------------
// traffic_light_sequencer_core
// three-lamp light sequencer driven by tick, button and mode command items
// ----------------------------------------------------------------------------
module traffic_light_sequencer_core #(
  parameter int TIME_BITS = tls_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // item channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_req_type,
  input  logic [1:0]                     in_new_mode,
  input  logic [tls_pkg::POT_BITS-1:0]   in_pot_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_mode,
  output logic [2:0]                     out_phase,
  output logic                           out_red_on,
  output logic                           out_yellow_on,
  output logic                           out_green_on,
  output logic [tls_pkg::LEVEL_BITS-1:0] out_level,
  // register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [tls_pkg::CFG_BITS-1:0]   cfg_data
);

  // input register
  logic                          in_v_r;
  tls_pkg::item_t                item_r;
  logic [tls_pkg::POT_BITS-1:0]  pot_r;

  // sequencer state
  tls_pkg::ctrl_t                ctrl_r;
  tls_pkg::ctrl_t                ctrl_nxt;
  logic [TIME_BITS-1:0]          elapsed_r;
  logic [TIME_BITS-1:0]          elapsed_nxt;
  tls_pkg::cfg_t                 cfg_r;

  // result register
  logic                          out_v_r;
  tls_pkg::mode_t                mode_r;
  tls_pkg::phase_t               phase_r;
  logic [2:0]                    lamps_r;
  logic [tls_pkg::LEVEL_BITS-1:0] level_r;

  logic [tls_pkg::LEVEL_BITS-1:0] tick_level;
  logic                          advance;

  // the held item moves on whenever the result register is free or being emptied
  assign advance   = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && out_v_r && out_stall;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.req_type <= in_req_type;
      item_r.new_mode <= in_new_mode;
      pot_r           <= in_pot_value;
    end
  end

  // ---------------------------------------------------------------- config regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_time    <= tls_pkg::RED_TIME_RESET;
      cfg_r.yellow_time <= tls_pkg::YELLOW_TIME_RESET;
      cfg_r.green_time  <= tls_pkg::GREEN_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tls_pkg::CFG_RED_TIME:    cfg_r.red_time    <= cfg_data;
        tls_pkg::CFG_YELLOW_TIME: cfg_r.yellow_time <= cfg_data;
        tls_pkg::CFG_GREEN_TIME:  cfg_r.green_time  <= cfg_data;
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- next state
  tls_level u_level (
    .pot   (pot_r),
    .level (tick_level)
  );

  tls_seq #(
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .cur         (ctrl_r),
    .elapsed_cur (elapsed_r),
    .item        (item_r),
    .cfg         (cfg_r),
    .tick_level  (tick_level),
    .nxt         (ctrl_nxt),
    .elapsed_nxt (elapsed_nxt)
  );

  // state moves only when an item passes into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.mode         <= tls_pkg::MODE_CYCLE;
      ctrl_r.phase        <= tls_pkg::PH_RED;
      ctrl_r.toggle_count <= 3'd0;
      ctrl_r.blink_lit    <= 1'b0;
      ctrl_r.lamps        <= tls_pkg::LAMP_RED;
      ctrl_r.level        <= tls_pkg::LEVEL_BITS'(tls_pkg::LEVEL_RESET);
      elapsed_r           <= '0;
    end else if (advance) begin
      ctrl_r    <= ctrl_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // ---------------------------------------------------------------- result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode_r  <= ctrl_nxt.mode;
      // phase only has meaning in cycle mode
      phase_r <= (ctrl_nxt.mode == tls_pkg::MODE_CYCLE) ? ctrl_nxt.phase : tls_pkg::PH_RED;
      lamps_r <= ctrl_nxt.lamps;
      level_r <= ctrl_nxt.level;
    end
  end

  assign out_valid     = out_v_r;
  assign out_mode      = mode_r;
  assign out_phase     = phase_r;
  assign out_red_on    = lamps_r[0];
  assign out_yellow_on = lamps_r[1];
  assign out_green_on  = lamps_r[2];
  assign out_level     = level_r;

  // ---------------------------------------------------------------- checks
  a_advance_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("item left the input stage without reaching the result register");

  a_phase_outside_cycle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mode != tls_pkg::MODE_CYCLE) |-> (out_phase == tls_pkg::PH_RED))
    else $error("phase reported outside cycle mode");

  a_off_mode_dark : assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r.mode == tls_pkg::MODE_OFF) |-> (ctrl_r.lamps == tls_pkg::LAMP_OFF))
    else $error("lamp lit in off mode");

  a_toggle_bound : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.toggle_count < 3'(tls_pkg::GREEN_TOGGLES))
    else $error("green toggle count overran");

  a_state_held_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(ctrl_r) && $stable(elapsed_r))
    else $error("sequencer state moved with no item passing");

endmodule
